// ----- hw/rtl/agsat_pkg.sv -----
// Package for the audio gain and saturation block.
// Holds the transaction structs, format codes, register indexes and limits.
// No dependencies.
`timescale 1ns / 1ps

package agsat_pkg;

	// Storage format codes
	localparam logic [2:0] FMT_S8      = 3'd0;
	localparam logic [2:0] FMT_U8      = 3'd1;
	localparam logic [2:0] FMT_S16_MSB = 3'd2;
	localparam logic [2:0] FMT_S16_LSB = 3'd3;
	localparam logic [2:0] FMT_U16_MSB = 3'd4;
	localparam logic [2:0] FMT_U16_LSB = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;

	localparam int GAIN_W   = 24;
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = SAMPLE_W + GAIN_W;
	localparam int CNT_W    = 31;

	localparam logic [2:0]               FORMAT_RESET = FMT_S16_MSB;
	localparam logic signed [GAIN_W-1:0] GAIN_RESET   = 24'sd65536;
	localparam logic [CNT_W-1:0]         CLIP_MAX     = 31'h7FFF_FFFF;

	// Input transaction
	typedef struct packed {
		logic [15:0] sample_bytes;
		logic        last_in;
	} in_t;

	// Result transaction
	typedef struct packed {
		logic [15:0]      scaled_bytes;
		logic             clipped;
		logic [CNT_W-1:0] clip_total;
		logic             last_out;
	} out_t;

	// Format flags that travel with each sample
	typedef struct packed {
		logic eight;
		logic is_signed;
		logic msb_first;
		logic last;
	} fmt_flags_t;

	// Decoded sample between the decode and multiply stages
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		fmt_flags_t                 flags;
	} dec_t;

	// Product between the multiply and output stages
	typedef struct packed {
		logic signed [PROD_W-1:0] product;
		fmt_flags_t               flags;
	} prod_t;

	// Configuration register values
	typedef struct packed {
		logic [2:0]               format;
		logic signed [GAIN_W-1:0] gain;
	} cfg_t;

endpackage

// ----- hw/rtl/audio_gain_saturate_top.sv -----
// A sample is registered in the input register, then in the result register.
// Throughput: one sample per cycle; two registered stages (decode into the input register,
// then multiply, round and saturate into the result register) each advance whenever the
// next one is empty or moving, so the input stalls only while both are full and the result
// is stalled.
// Reset: arst_n clears stage valids and the clip count, format to s16 msb-first, gain to 1.0.
`timescale 1ns / 1ps

module audio_gain_saturate_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  agsat_pkg::in_t                  sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output agsat_pkg::out_t                 result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [agsat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [agsat_pkg::GAIN_W-1:0]    cfg_data
);
	import agsat_pkg::*;

	cfg_t  cfg;
	logic  dec_ready;
	logic  dec_valid;
	dec_t  dec_data;
	prod_t mult_data;
	logic  sat_ready;

	// Configuration registers
	agsat_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Decode stage
	agsat_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.format   (cfg.format),
		.up_valid (sample_valid),
		.up_ready (dec_ready),
		.up_data  (sample),
		.dn_valid (dec_valid),
		.dn_ready (sat_ready),
		.dn_data  (dec_data)
	);

	// Multiplier feeding the result stage
	agsat_mult u_mult (
		.gain    (cfg.gain),
		.up_data (dec_data),
		.dn_data (mult_data)
	);

	// Round, saturate and encode stage
	agsat_sat u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dec_valid),
		.up_ready (sat_ready),
		.up_data  (mult_data),
		.dn_valid (result_valid),
		.dn_ready (!result_stall),
		.dn_data  (result)
	);

	assign sample_stall = !dec_ready;

endmodule

// ----- hw/rtl/agsat_cfg.sv -----
// Configuration registers of the audio gain block: sample format and gain.
// Depends on agsat_pkg.
`timescale 1ns / 1ps

module agsat_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [agsat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [agsat_pkg::GAIN_W-1:0]     cfg_data,
	output agsat_pkg::cfg_t                  cfg
);
	import agsat_pkg::*;

	logic [2:0]               format_q;
	logic signed [GAIN_W-1:0] gain_q;

	// Writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FORMAT_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FORMAT: format_q <= cfg_data[2:0];
				CFG_GAIN:   gain_q   <= $signed(cfg_data);
				default:    ;
			endcase
		end
	end

	assign cfg.format = format_q;
	assign cfg.gain   = gain_q;

endmodule

// ----- hw/rtl/agsat_decode.sv -----
// First stage: decodes the stored sample into a signed value and registers it.
// Depends on agsat_pkg.
`timescale 1ns / 1ps

module agsat_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      format,
	input  logic            up_valid,
	output logic            up_ready,
	input  agsat_pkg::in_t  up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output agsat_pkg::dec_t dn_data
);
	import agsat_pkg::*;

	logic       valid_s1;
	dec_t       data_s1;
	logic [2:0] fmt;
	fmt_flags_t flags;
	logic [7:0] b8;
	logic [15:0] w16;
	logic signed [SAMPLE_W-1:0] value;

	// Unused codes fall back to signed 16-bit msb-first.
	always_comb begin
		fmt = (format > FMT_U16_LSB) ? FMT_S16_MSB : format;
		flags.eight     = (fmt == FMT_S8) || (fmt == FMT_U8);
		flags.is_signed = (fmt == FMT_S8) || (fmt == FMT_S16_MSB) ||
			(fmt == FMT_S16_LSB);
		flags.msb_first = (fmt == FMT_S16_MSB) || (fmt == FMT_U16_MSB);
		flags.last      = up_data.last_in;
	end

	// Removing the unsigned bias is the same as flipping the top bit.
	always_comb begin
		b8  = up_data.sample_bytes[7:0];
		w16 = flags.msb_first ? up_data.sample_bytes :
			{up_data.sample_bytes[7:0], up_data.sample_bytes[15:8]};
		if (flags.eight) begin
			value = $signed({{(SAMPLE_W-8){b8[7] ~^ flags.is_signed}},
				b8[7] ~^ flags.is_signed, b8[6:0]});
		end else begin
			value = $signed({w16[15] ~^ flags.is_signed, w16[14:0]});
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1.sample <= value;
			data_s1.flags  <= flags;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

// ----- hw/rtl/agsat_mult.sv -----
// Multiplier between the input register and the result register of the audio gain block.
// Depends on agsat_pkg.
`timescale 1ns / 1ps

module agsat_mult (
	input  logic signed [agsat_pkg::GAIN_W-1:0] gain,
	input  agsat_pkg::dec_t                     up_data,
	output agsat_pkg::prod_t                    dn_data
);
	import agsat_pkg::*;

	// Exact signed product, 16 by 24 bits; the format flags pass straight through.
	assign dn_data.product = up_data.sample * gain;
	assign dn_data.flags   = up_data.flags;

endmodule

// ----- hw/rtl/agsat_sat.sv -----
// Output stage: rounds, saturates, re-encodes and counts clipped samples.
// Depends on agsat_pkg.
`timescale 1ns / 1ps

module agsat_sat (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  agsat_pkg::prod_t up_data,
	output logic             dn_valid,
	input  logic             dn_ready,
	output agsat_pkg::out_t  dn_data
);
	import agsat_pkg::*;

	localparam int Q_W = PROD_W + 1 - 16;

	logic                     valid_s3;
	out_t                     data_s3;
	logic [CNT_W-1:0]         clip_cnt_q;
	logic signed [PROD_W:0]   rounded;
	logic signed [Q_W-1:0]    q;
	logic signed [Q_W-1:0]    hi;
	logic signed [Q_W-1:0]    lo;
	logic signed [Q_W-1:0]    qs;
	logic                     clip;
	logic [15:0]              w16;
	logic [15:0]              enc;
	logic [CNT_W-1:0]         cnt_next;
	logic                     take;

	// Round half up: add one half, then floor by dropping 16 fraction bits.
	always_comb begin
		rounded = {up_data.product[PROD_W-1], up_data.product} +
			$signed((PROD_W+1)'(32'h8000));
		q = rounded[PROD_W:16];
	end

	// Saturate to the 8- or 16-bit signed range.
	always_comb begin
		hi = up_data.flags.eight ? Q_W'(32'sd127) : Q_W'(32'sd32767);
		lo = up_data.flags.eight ? Q_W'(-32'sd128) : Q_W'(-32'sd32768);
		clip = 1'b0;
		qs   = q;
		if (q > hi) begin
			qs   = hi;
			clip = 1'b1;
		end
		if (q < lo) begin
			qs   = lo;
			clip = 1'b1;
		end
	end

	// Re-encode: unsigned formats flip the top bit, lsb-first swaps bytes.
	always_comb begin
		w16 = {qs[15] ^ !up_data.flags.is_signed, qs[14:0]};
		if (up_data.flags.eight) begin
			enc = {8'h00, qs[7] ^ !up_data.flags.is_signed, qs[6:0]};
		end else if (up_data.flags.msb_first) begin
			enc = w16;
		end else begin
			enc = {w16[7:0], w16[15:8]};
		end
	end

	// Saturating clip count for the current buffer.
	assign cnt_next = (clip && (clip_cnt_q != CLIP_MAX)) ? clip_cnt_q + 31'd1 : clip_cnt_q;
	assign up_ready = !valid_s3 || dn_ready;
	assign take     = up_ready && up_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3   <= 1'b0;
			clip_cnt_q <= '0;
		end else begin
			if (up_ready) begin
				valid_s3 <= up_valid;
			end
			if (take) begin
				clip_cnt_q <= up_data.flags.last ? '0 : cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s3.scaled_bytes <= enc;
			data_s3.clipped      <= clip;
			data_s3.clip_total   <= cnt_next;
			data_s3.last_out     <= up_data.flags.last;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule

// ----- hw/rtl/agsat_checker.sv -----
// Port-level checker for the audio gain block, bound to the top level.
// Depends on agsat_pkg and audio_gain_saturate_top.
`timescale 1ns / 1ps

module agsat_port_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_stall,
	input  logic            result_valid,
	input  logic            result_stall,
	input  agsat_pkg::out_t result
);
	import agsat_pkg::*;

	// A stalled result transaction holds until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

	// With no result pending the pipeline has room, so input is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("input stalled while output empty");

	// A clipped sample is always counted in the buffer total.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.clipped |-> result.clip_total != '0)
		else $error("clipped sample with zero clip total");

	// After an input stall clears, the previous cycle had a result waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_stall) |-> $past(result_valid))
		else $error("input stall without pending result");

endmodule

bind audio_gain_saturate_top agsat_port_checker u_agsat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
